[rtl/assert_macros.svh]
// Assertion macros used by the tree store top module.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[rtl/abst_pkg.sv]
// Types and codes for the implicit-array binary search tree.
// Depends on nothing.
package abst_pkg;
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_MIN    = 2'd2;
  localparam logic [1:0] ACT_MAX    = 2'd3;
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_NOROOM = 3'd2;
  localparam logic [2:0] ST_MISS   = 3'd3;
  localparam logic [2:0] ST_ZERO   = 3'd4;
  localparam int unsigned IDX_W = 10;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               found;
    logic [5:0]         slot;
    logic signed [31:0] value;
  } rsp_t;

  // Walk token handed from one tree level to the next.
  typedef struct packed {
    logic               act;
    logic               done;
    req_t               req;
    logic [IDX_W-1:0]   idx;
    logic               wr;
    rsp_t               rsp;
  } tok_t;
endpackage

[rtl/abst_ram.sv]
// Generic single-port RAM with registered read.
// Depends on nothing.
module abst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/abst_level.sv]
// One tree level: holds the slots of its depth and steps the walk token.
// Depends on abst_pkg and abst_ram.
module abst_level #(
  parameter int unsigned LEVEL = 0,
  parameter int unsigned NODES = 63
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_i,
  input  abst_pkg::tok_t  tok_i,
  output abst_pkg::tok_t  tok_o
);
  import abst_pkg::*;

  localparam int unsigned FIRST = (1 << LEVEL) - 1;
  localparam int unsigned CNT   = 1 << LEVEL;
  localparam int unsigned AW    = (LEVEL == 0) ? 1 : LEVEL;

  logic [CNT-1:0]     vld_q;
  logic [AW-1:0]      addr;
  logic [IDX_W-1:0]   ofs;
  logic [31:0]        rdata;
  tok_t               t_q;
  tok_t               nx;
  logic signed [31:0] cur;
  logic               occ;
  logic [IDX_W:0]     lc;
  logic [IDX_W:0]     rc;
  logic [IDX_W:0]     nidx;

  assign ofs  = tok_i.idx - IDX_W'(FIRST);
  assign addr = (LEVEL == 0) ? '0 : AW'(ofs);

  abst_ram #(.WIDTH(32), .DEPTH(CNT), .AW(AW)) u_ram (
    .clk_i  (clk_i),
    .we_i   (tok_o.wr && tok_o.act),
    .addr_i (tok_o.wr ? AW'(tok_o.idx - IDX_W'(FIRST)) : addr),
    .wdata_i(tok_o.rsp.value),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      t_q   <= '0;
    end else begin
      t_q <= tok_i;
      if (clr_i) begin
        vld_q <= '0;
      end else if (tok_o.act && tok_o.wr) begin
        vld_q[AW'(tok_o.idx - IDX_W'(FIRST))] <= 1'b1;
      end
    end
  end

  always_comb begin
    occ  = vld_q[AW'(t_q.idx - IDX_W'(FIRST))];
    cur  = occ ? $signed(rdata) : 32'sd0;
    lc   = {t_q.idx, 1'b1};
    rc   = {t_q.idx, 1'b0} + (IDX_W+1)'(2);
    nidx = lc;
    nx   = t_q;
    nx.wr = 1'b0;
    if (t_q.act && !t_q.done) begin
      if (t_q.req.action == ACT_MIN || t_q.req.action == ACT_MAX) begin
        if (!occ) begin
          nx.done = 1'b1;
          if (LEVEL == 0) begin
            nx.rsp = '{ST_MISS, 1'b0, 6'd0, 32'sd0};
          end
        end else begin
          nidx = (t_q.req.action == ACT_MIN) ? lc : rc;
          nx.rsp = '{ST_OK, 1'b0, t_q.idx[5:0], cur};
          if (nidx >= (IDX_W+1)'(NODES)) begin
            nx.done = 1'b1;
          end else begin
            nx.idx = IDX_W'(nidx);
          end
        end
      end else if (!occ) begin
        nx.done = 1'b1;
        if (t_q.req.action == ACT_INSERT) begin
          nx.wr  = 1'b1;
          nx.rsp = '{ST_OK, 1'b1, t_q.idx[5:0], t_q.req.key};
        end else begin
          nx.rsp = '{ST_MISS, 1'b0, 6'd0, 32'sd0};
        end
      end else if (t_q.req.key == cur) begin
        nx.done = 1'b1;
        nx.rsp = (t_q.req.action == ACT_INSERT) ?
                 '{ST_DUP, 1'b0, t_q.idx[5:0], cur} :
                 '{ST_OK, 1'b1, t_q.idx[5:0], cur};
      end else begin
        nidx = (t_q.req.key > cur) ? rc : lc;
        if (nidx >= (IDX_W+1)'(NODES)) begin
          nx.done = 1'b1;
          nx.rsp = (t_q.req.action == ACT_INSERT) ?
                   '{ST_NOROOM, 1'b0, 6'd0, 32'sd0} :
                   '{ST_MISS, 1'b0, 6'd0, 32'sd0};
        end else begin
          nx.idx = IDX_W'(nidx);
        end
      end
    end
  end

  assign tok_o = nx;
endmodule

[rtl/array_bst_insert_search.sv]
// Implicit-array binary search tree with insert, search, min and max.
// Path: an accepted request passes a register in each tree level and then the result
// register, one per tree level and one for the result register, before the beat is offered.
// Throughput: one item at a time; the input stays stalled until the result beat is taken.
// Reset empties the tree at once through per-slot valid bits.
module array_bst_insert_search #(
  parameter int unsigned NODES = 63
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  abst_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output abst_pkg::rsp_t out_data_o
);
  import abst_pkg::*;

  localparam int unsigned LEVELS = $clog2(NODES + 1);

  tok_t tok [LEVELS+1];
  logic busy_q;
  logic ovld_q;
  rsp_t odat_q;
  tok_t head;

  always_comb begin
    head = '0;
    head.act = in_valid_i && !in_stall_o;
    head.req = in_data_i;
    if ((in_data_i.action == ACT_INSERT || in_data_i.action == ACT_SEARCH) &&
        in_data_i.key == 32'sd0) begin
      head.done = 1'b1;
      head.rsp  = '{ST_ZERO, 1'b0, 6'd0, 32'sd0};
    end
  end

  assign tok[0] = head;

  for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
    abst_level #(.LEVEL(g), .NODES(NODES)) u_lvl (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .clr_i (1'b0),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = ovld_q;
  assign out_data_o  = odat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ovld_q <= 1'b0;
      odat_q <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        busy_q <= 1'b1;
      end
      if (tok[LEVELS].act) begin
        ovld_q <= 1'b1;
        odat_q <= tok[LEVELS].rsp;
      end else if (ovld_q && !out_stall_i) begin
        ovld_q <= 1'b0;
        busy_q <= 1'b0;
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPLIES(a_busy_out, clk_i, rst_ni, ovld_q, busy_q)
  `ASSERT_IMPLIES(a_no_take, clk_i, rst_ni, busy_q, in_stall_o)
  `ASSERT_NEXT(a_result, clk_i, rst_ni, tok[LEVELS].act, ovld_q)
endmodule

[verif/tb.sv]
// Testbench for array_bst_insert_search: drives insert, search, min and max beats
// and checks every response against a local model of the implicit-array tree.
// Depends on abst_pkg and the array_bst_insert_search RTL.
`timescale 1ns / 1ps
module tb;
  import abst_pkg::*;

  localparam int unsigned TREE_SLOTS = 63;
  localparam int unsigned RANDOM_BEATS = 400;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  logic signed [31:0] tree_model [TREE_SLOTS];
  rsp_t pending_rsp [$];
  int unsigned error_count;
  int unsigned rsp_count;
  int unsigned act_count [4];
  logic hold_off;

  typedef struct {
    logic [1:0]         act;
    logic signed [31:0] key;
    logic               fixed;
    rsp_t               rsp;
  } stim_row_t;

  array_bst_insert_search #(.NODES(TREE_SLOTS)) u_top (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_data_o(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic rsp_t mk_rsp(logic [2:0] st, logic fd, logic [5:0] sl,
                                  logic signed [31:0] v);
    rsp_t r;
    r.status = st;
    r.found = fd;
    r.slot = sl;
    r.value = v;
    return r;
  endfunction

  function automatic rsp_t tree_apply(req_t rq);
    int unsigned idx;
    int unsigned child;
    logic signed [31:0] cur;
    idx = 0;
    if (rq.action == ACT_MIN || rq.action == ACT_MAX) begin
      if (tree_model[0] == 0) return mk_rsp(ST_MISS, 1'b0, '0, '0);
      forever begin
        child = (rq.action == ACT_MIN) ? 2 * idx + 1 : 2 * idx + 2;
        if (child >= TREE_SLOTS || tree_model[child] == 0) break;
        idx = child;
      end
      return mk_rsp(ST_OK, 1'b0, idx[5:0], tree_model[idx]);
    end
    if (rq.key == 0) return mk_rsp(ST_ZERO, 1'b0, '0, '0);
    while (idx < TREE_SLOTS) begin
      cur = tree_model[idx];
      if (cur == 0) begin
        if (rq.action == ACT_INSERT) begin
          tree_model[idx] = rq.key;
          return mk_rsp(ST_OK, 1'b1, idx[5:0], rq.key);
        end
        return mk_rsp(ST_MISS, 1'b0, '0, '0);
      end
      if (rq.key == cur) begin
        if (rq.action == ACT_INSERT) return mk_rsp(ST_DUP, 1'b0, idx[5:0], cur);
        return mk_rsp(ST_OK, 1'b1, idx[5:0], cur);
      end
      idx = (rq.key > cur) ? 2 * idx + 2 : 2 * idx + 1;
    end
    if (rq.action == ACT_INSERT) return mk_rsp(ST_NOROOM, 1'b0, '0, '0);
    return mk_rsp(ST_MISS, 1'b0, '0, '0);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("tb: mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
    error_count++;
  endtask

  task automatic send_beat(logic [1:0] act, logic signed [31:0] key, logic fixed,
                           rsp_t fixed_rsp);
    req_t rq;
    rsp_t want;
    rq.action = act;
    rq.key = key;
    in_data <= rq;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    want = tree_apply(rq);
    if (fixed && want != fixed_rsp) report_mismatch("table row", 64'(fixed_rsp), 64'(want));
    pending_rsp.push_back(want);
    act_count[act]++;
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Keys mostly drawn from a small pool so that duplicates and hits are common.
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'sh7fffffff - $urandom_range(0, 3);
      2: return 32'sh80000000 + $urandom_range(0, 3);
      3: return 0;
      default: return $signed($urandom_range(0, 80)) - 40;
    endcase
  endfunction

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      rsp_count++;
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_data.value), '0);
      end else begin
        rsp_t want;
        want = pending_rsp.pop_front();
        if (out_data.status != want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
        if (out_data.found != want.found)
          report_mismatch("found", 64'(out_data.found), 64'(want.found));
        if (out_data.slot != want.slot)
          report_mismatch("slot", 64'(out_data.slot), 64'(want.slot));
        if (out_data.value != want.value)
          report_mismatch("value", 64'(out_data.value), 64'(want.value));
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) out_stall <= 1'b1;
      else if ($urandom_range(0, 1)) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    hold_off = 1'b0;
    @(posedge rst_n);
    repeat (300) @(negedge clk);
    hold_off = 1'b1;
    repeat (120) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t r;
    int unsigned n;
    logic [1:0] act;
    logic signed [31:0] key;
    error_count = 0;
    rsp_count = 0;
    foreach (act_count[k]) act_count[k] = 0;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    foreach (tree_model[k]) tree_model[k] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    rows = '{
      '{ACT_MIN,    32'sd0,          1'b1, mk_rsp(ST_MISS, 1'b0, 6'd0, 32'sd0)},
      '{ACT_MAX,    32'sd0,          1'b1, mk_rsp(ST_MISS, 1'b0, 6'd0, 32'sd0)},
      '{ACT_SEARCH, 32'sd5,          1'b1, mk_rsp(ST_MISS, 1'b0, 6'd0, 32'sd0)},
      '{ACT_INSERT, 32'sd0,          1'b1, mk_rsp(ST_ZERO, 1'b0, 6'd0, 32'sd0)},
      '{ACT_SEARCH, 32'sd0,          1'b1, mk_rsp(ST_ZERO, 1'b0, 6'd0, 32'sd0)},
      '{ACT_INSERT, 32'sd10,         1'b1, mk_rsp(ST_OK, 1'b1, 6'd0, 32'sd10)},
      '{ACT_INSERT, 32'sd10,         1'b1, mk_rsp(ST_DUP, 1'b0, 6'd0, 32'sd10)},
      '{ACT_INSERT, 32'sh80000000,   1'b1, mk_rsp(ST_OK, 1'b1, 6'd1, 32'sh80000000)},
      '{ACT_INSERT, 32'sh7fffffff,   1'b1, mk_rsp(ST_OK, 1'b1, 6'd2, 32'sh7fffffff)},
      '{ACT_MIN,    32'sd0,          1'b1, mk_rsp(ST_OK, 1'b0, 6'd1, 32'sh80000000)},
      '{ACT_MAX,    32'sd0,          1'b1, mk_rsp(ST_OK, 1'b0, 6'd2, 32'sh7fffffff)},
      '{ACT_SEARCH, 32'sh7fffffff,   1'b1, mk_rsp(ST_OK, 1'b1, 6'd2, 32'sh7fffffff)},
      '{ACT_SEARCH, 32'sd11,         1'b0, '0},
      '{ACT_INSERT, 32'sd11,         1'b0, '0},
      '{ACT_INSERT, 32'sd12,         1'b0, '0},
      '{ACT_INSERT, 32'sd13,         1'b0, '0},
      '{ACT_INSERT, 32'sd14,         1'b0, '0},
      '{ACT_INSERT, 32'sd15,         1'b0, '0},
      '{ACT_INSERT, 32'sd16,         1'b0, '0},
      '{ACT_INSERT, 32'sd17,         1'b0, '0},
      '{ACT_SEARCH, 32'sd17,         1'b0, '0},
      '{ACT_SEARCH, 32'sd18,         1'b0, '0},
      '{ACT_MAX,    32'sh5555aaaa,   1'b0, '0},
      '{ACT_MIN,    32'shaaaa5555,   1'b0, '0}
    };
    foreach (rows[k]) begin
      r = rows[k];
      send_beat(r.act, r.key, r.fixed, r.rsp);
    end

    n = 0;
    while (n < RANDOM_BEATS) begin
      repeat ($urandom_range(1, 12)) begin
        act = $urandom_range(0, 9) < 5 ? ACT_INSERT : ACT_SEARCH;
        if ($urandom_range(0, 7) == 0) act = $urandom_range(0, 1) ? ACT_MIN : ACT_MAX;
        key = pick_key();
        send_beat(act, key, 1'b0, '0);
        n++;
      end
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b0;

    fork
      wait (pending_rsp.size() == 0);
      begin
        repeat (20000) @(posedge clk);
      end
    join_any
    disable fork;
    repeat (20) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $display("tb: %0d responses never arrived", pending_rsp.size());
      error_count++;
    end
    $display("tb: %0d beats checked: %0d insert, %0d search, %0d min, %0d max",
             rsp_count, act_count[0], act_count[1], act_count[2], act_count[3]);
    $display("tb: covered zero keys, extreme keys, duplicates, full paths and stalls");
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
